// ----- rtl/sptx_pkg.sv -----
// sptx_pkg: types, codes and helper functions shared by the stick packet encoder.
// Used by sptx_front, sptx_queue, sptx_back and the top level; no dependencies.
package sptx_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_YAW_CENTER   = 3'd0;
	localparam logic [2:0] REG_ROLL_CENTER  = 3'd1;
	localparam logic [2:0] REG_PITCH_CENTER = 3'd2;

	// key codes from the resistor ladder
	localparam logic [2:0] KEY_NONE       = 3'd0;
	localparam logic [2:0] KEY_YAW_UP     = 3'd1;
	localparam logic [2:0] KEY_YAW_DOWN   = 3'd2;
	localparam logic [2:0] KEY_PITCH_UP   = 3'd3;
	localparam logic [2:0] KEY_PITCH_DOWN = 3'd4;
	localparam logic [2:0] KEY_ROLL_DOWN  = 3'd5;
	localparam logic [2:0] KEY_ROLL_UP    = 3'd6;

	// arm mode codes
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_LOCK   = 3'd1;
	localparam logic [2:0] MODE_UNLOCK = 3'd5;

	// byte positions inside a packet
	localparam int BYTE_SEQ        = 0;
	localparam int BYTE_MODE       = 1;
	localparam int BYTE_THR_HI     = 2;
	localparam int BYTE_THR_LO     = 3;
	localparam int BYTE_YAW        = 4;
	localparam int BYTE_ROLL       = 5;
	localparam int BYTE_PITCH      = 6;
	localparam int BYTE_ROLL_TRIM  = 7;
	localparam int BYTE_PITCH_TRIM = 8;
	localparam int BYTE_YAW_TRIM   = 9;
	localparam int BYTE_SUM        = 10;

	localparam logic [9:0] THR_MAX     = 10'd1000;
	localparam logic [9:0] THR_ARM_MAX = 10'd5;
	localparam logic [7:0] AXIS_MID    = 8'd128;
	localparam logic [7:0] TRIM_RESET  = 8'd128;
	localparam logic [7:0] CENTER_RESET = 8'd128;

	// one classified item, ready to be serialized
	typedef struct packed {
		logic [7:0] seq;
		logic [2:0] mode;
		logic [1:0] thr_hi;
		logic [7:0] thr_lo;
		logic [7:0] yaw;
		logic [7:0] roll;
		logic [7:0] pitch;
		logic [7:0] roll_trim;
		logic [7:0] pitch_trim;
		logic [7:0] yaw_trim;
	} pkt_rec_t;

	// deadband of +-5 around the center, half slope outside
	function automatic logic [7:0] map_axis(input logic [7:0] s, input logic [7:0] c);
		logic [8:0] s9;
		logic [8:0] c9;
		logic [8:0] d;
		logic [7:0] v;
		s9 = {1'b0, s};
		c9 = {1'b0, c};
		d  = '0;
		if (s9 > c9 + 9'd5) begin
			d = s9 - c9 - 9'd5;
			v = 8'(9'(AXIS_MID) + (d >> 1));
		end else if (s9 + 9'd5 < c9) begin
			d = c9 - s9 - 9'd5;
			v = 8'(9'(AXIS_MID) - (d >> 1));
		end else begin
			v = AXIS_MID;
		end
		return v;
	endfunction

	// ladder windows; between windows the previous code holds
	function automatic logic [2:0] ladder_code(input logic [7:0] a, input logic [2:0] prev);
		logic [2:0] k;
		if (a <= 8'd2)                      k = KEY_NONE;
		else if (a > 8'd35  && a < 8'd43)   k = KEY_YAW_UP;
		else if (a > 8'd70  && a < 8'd80)   k = KEY_YAW_DOWN;
		else if (a > 8'd108 && a < 8'd117)  k = KEY_PITCH_UP;
		else if (a > 8'd146 && a < 8'd156)  k = KEY_PITCH_DOWN;
		else if (a > 8'd192 && a < 8'd202)  k = KEY_ROLL_DOWN;
		else if (a > 8'd250)                k = KEY_ROLL_UP;
		else                                k = prev;
		return k;
	endfunction

endpackage

// ----- rtl/sptx_front.sv -----
// sptx_front: accepts sample sets, scales the sticks, decodes keys and buttons
// and keeps the trim, mode and sequence state. Depends on sptx_pkg.
module sptx_front
	import sptx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       accept,
	input  logic [9:0] throttle_sample,
	input  logic [9:0] yaw_sample,
	input  logic [9:0] roll_sample,
	input  logic [9:0] pitch_sample,
	input  logic [9:0] ladder_sample,
	input  logic       lock_pressed,
	input  logic       unlock_pressed,
	output pkt_rec_t   rec
);

	logic [7:0] yaw_center_q, roll_center_q, pitch_center_q;
	logic [7:0] seq_q;
	logic [2:0] mode_q;
	logic [2:0] key_q;
	logic [7:0] yaw_trim_q, roll_trim_q, pitch_trim_q;

	logic [9:0] thr;
	logic [1:0] thr_hi;
	logic [9:0] thr_lo;
	logic [2:0] key_d;
	logic [2:0] mode_d;
	logic [7:0] yaw_trim_d, roll_trim_d, pitch_trim_d;
	logic       key_step;

	// the center registers reset to 128 and load on cfg writes; other indexes are
	// ignored, and the trims simply reset to 128
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_center_q   <= CENTER_RESET;
			roll_center_q  <= CENTER_RESET;
			pitch_center_q <= CENTER_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_YAW_CENTER:   yaw_center_q   <= cfg_data;
				REG_ROLL_CENTER:  roll_center_q  <= cfg_data;
				REG_PITCH_CENTER: pitch_center_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		thr = (throttle_sample > THR_MAX) ? THR_MAX : throttle_sample;
		if (thr >= 10'd765)      thr_hi = 2'd3;
		else if (thr >= 10'd510) thr_hi = 2'd2;
		else if (thr >= 10'd255) thr_hi = 2'd1;
		else                     thr_hi = 2'd0;
		thr_lo = thr - 10'(thr_hi) * 10'd255;

		key_d    = ladder_code(ladder_sample[9:2], key_q);
		key_step = (key_d != KEY_NONE) && (key_d != key_q);
		yaw_trim_d   = yaw_trim_q;
		roll_trim_d  = roll_trim_q;
		pitch_trim_d = pitch_trim_q;
		if (key_step) begin
			case (key_d)
				KEY_YAW_UP:     yaw_trim_d   = yaw_trim_q + 8'd1;
				KEY_YAW_DOWN:   yaw_trim_d   = yaw_trim_q - 8'd1;
				KEY_PITCH_UP:   pitch_trim_d = pitch_trim_q + 8'd1;
				KEY_PITCH_DOWN: pitch_trim_d = pitch_trim_q - 8'd1;
				KEY_ROLL_DOWN:  roll_trim_d  = roll_trim_q - 8'd1;
				KEY_ROLL_UP:    roll_trim_d  = roll_trim_q + 8'd1;
				default: ;
			endcase
		end

		// unlock wins over lock when both are held at low throttle
		mode_d = mode_q;
		if (lock_pressed) mode_d = MODE_LOCK;
		if (unlock_pressed && thr < THR_ARM_MAX) mode_d = MODE_UNLOCK;

		rec.seq        = seq_q;
		rec.mode       = mode_d;
		rec.thr_hi     = thr_hi;
		rec.thr_lo     = thr_lo[7:0];
		rec.yaw        = map_axis(yaw_sample[9:2], yaw_center_q);
		rec.roll       = map_axis(roll_sample[9:2], roll_center_q);
		rec.pitch      = map_axis(pitch_sample[9:2], pitch_center_q);
		rec.roll_trim  = roll_trim_d;
		rec.pitch_trim = pitch_trim_d;
		rec.yaw_trim   = yaw_trim_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= '0;
			mode_q       <= MODE_IDLE;
			key_q        <= KEY_NONE;
			yaw_trim_q   <= TRIM_RESET;
			roll_trim_q  <= TRIM_RESET;
			pitch_trim_q <= TRIM_RESET;
		end else if (accept) begin
			seq_q        <= seq_q + 8'd1;
			mode_q       <= mode_d;
			key_q        <= key_d;
			yaw_trim_q   <= yaw_trim_d;
			roll_trim_q  <= roll_trim_d;
			pitch_trim_q <= pitch_trim_d;
		end
	end

endmodule

// ----- rtl/sptx_queue.sv -----
// sptx_queue: two-entry queue of classified items between front and back.
// Depends on sptx_pkg.
module sptx_queue
	import sptx_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  pkt_rec_t wr_data,
	output logic     full,
	input  logic     rd_en,
	output logic     rd_valid,
	output pkt_rec_t rd_data
);

	pkt_rec_t   mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/sptx_back.sv -----
// sptx_back: takes items from the queue, adds the checksum and sends the
// packet out one byte per pop. Depends on sptx_pkg.
module sptx_back
	import sptx_pkg::*;
#(
	parameter int PACKET_BYTES = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  pkt_rec_t   q_data,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] packet_byte,
	output logic       packet_end
);

	localparam int IDXW = $clog2(PACKET_BYTES);

	pkt_rec_t        cur_q;
	logic [7:0]      sum_q;
	logic [IDXW-1:0] idx_q;
	logic            busy_q;
	logic [7:0]      sum_d;
	logic            last;

	assign last       = (idx_q == IDXW'(PACKET_BYTES - 1));
	assign empty      = !busy_q;
	assign packet_end = last;
	assign q_pop      = q_valid && (!busy_q || (pop && last));

	always_comb begin
		sum_d = ((q_data.seq + {5'd0, q_data.mode}) + ({6'd0, q_data.thr_hi} + q_data.thr_lo))
		      + ((q_data.yaw + q_data.roll) + (q_data.pitch + q_data.roll_trim))
		      + (q_data.pitch_trim + q_data.yaw_trim);
	end

	always_comb begin
		case (idx_q)
			IDXW'(BYTE_SEQ):        packet_byte = cur_q.seq;
			IDXW'(BYTE_MODE):       packet_byte = {5'd0, cur_q.mode};
			IDXW'(BYTE_THR_HI):     packet_byte = {6'd0, cur_q.thr_hi};
			IDXW'(BYTE_THR_LO):     packet_byte = cur_q.thr_lo;
			IDXW'(BYTE_YAW):        packet_byte = cur_q.yaw;
			IDXW'(BYTE_ROLL):       packet_byte = cur_q.roll;
			IDXW'(BYTE_PITCH):      packet_byte = cur_q.pitch;
			IDXW'(BYTE_ROLL_TRIM):  packet_byte = cur_q.roll_trim;
			IDXW'(BYTE_PITCH_TRIM): packet_byte = cur_q.pitch_trim;
			IDXW'(BYTE_YAW_TRIM):   packet_byte = cur_q.yaw_trim;
			IDXW'(BYTE_SUM):        packet_byte = sum_q;
			default:                packet_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
			sum_q <= sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (pop && busy_q) begin
			if (last) busy_q <= 1'b0;
			else      idx_q  <= idx_q + IDXW'(1);
		end
	end

endmodule

// ----- rtl/stick_to_radio_packet_encoder_unit.sv -----
// stick_to_radio_packet_encoder_unit: top level of the stick packet encoder.
// Depends on sptx_pkg, sptx_front, sptx_queue and sptx_back.
//
// Each sample set pushed in becomes one radio packet of PACKET_BYTES bytes,
// popped one byte per cycle while pop is held, with packet_end on the last
// byte. The front decodes a sample set in the cycle it is pushed and holds
// the trim, mode and sequence state; a two-entry queue separates it from the
// byte serializer, so up to two packets may wait behind the one being sent.
// Sample sets are accepted while a packet is sent, until the queue is full;
// a new packet's first byte follows the previous last byte with no gap when
// the next item is already queued. The user is to write the center registers
// (index 0..2) through the cfg port while idle; the block does not enforce
// it. Indexes 3..5 are ignored, and the trims reset to 128.
module stick_to_radio_packet_encoder_unit
	import sptx_pkg::*;
#(
	parameter int PACKET_BYTES = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [9:0] throttle_sample,
	input  logic [9:0] yaw_sample,
	input  logic [9:0] roll_sample,
	input  logic [9:0] pitch_sample,
	input  logic [9:0] ladder_sample,
	input  logic       lock_pressed,
	input  logic       unlock_pressed,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] packet_byte,
	output logic       packet_end
);

	logic     accept;
	pkt_rec_t front_rec;
	logic     q_valid;
	logic     q_pop;
	pkt_rec_t q_data;

	assign accept = push && !full;

	sptx_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.accept          (accept),
		.throttle_sample (throttle_sample),
		.yaw_sample      (yaw_sample),
		.roll_sample     (roll_sample),
		.pitch_sample    (pitch_sample),
		.ladder_sample   (ladder_sample),
		.lock_pressed    (lock_pressed),
		.unlock_pressed  (unlock_pressed),
		.rec             (front_rec)
	);

	sptx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_data  (front_rec),
		.full     (full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_data)
	);

	sptx_back #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.packet_byte (packet_byte),
		.packet_end  (packet_end)
	);

endmodule

// ----- test/stick_to_radio_packet_encoder_unit_test.sv -----
// Regression bench for stick_to_radio_packet_encoder_unit: sends sample sets, predicts
// every packet byte in its own encoder model and checks each popped byte in order.
// Depends on sptx_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module stick_to_radio_packet_encoder_unit_test;
	import sptx_pkg::*;

	localparam int PACKET_BYTES  = 15;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 52;
	localparam int CENTER_RAW    = 512;

	localparam logic [2:0] REG_ROLL_TRIM_START  = 3'd3;
	localparam logic [2:0] REG_PITCH_TRIM_START = 3'd4;
	localparam logic [2:0] REG_YAW_TRIM_START   = 3'd5;

	typedef struct packed {
		logic [9:0] throttle;
		logic [9:0] yaw;
		logic [9:0] roll;
		logic [9:0] pitch;
		logic [9:0] ladder;
		logic       lock;
		logic       unlock;
	} sample_set_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} packet_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wen = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       push = 1'b0;
	logic       full;
	logic [9:0] throttle_sample = '0;
	logic [9:0] yaw_sample = '0;
	logic [9:0] roll_sample = '0;
	logic [9:0] pitch_sample = '0;
	logic [9:0] ladder_sample = '0;
	logic       lock_pressed = 1'b0;
	logic       unlock_pressed = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] packet_byte;
	logic       packet_end;

	// encoder model state and its copy of the registers
	logic [7:0] pkt_seq = '0;
	logic [2:0] arm_mode_now = MODE_IDLE;
	logic [2:0] held_key = KEY_NONE;
	logic [2:0] last_key = KEY_NONE;
	logic [7:0] trim_yaw = TRIM_RESET;
	logic [7:0] trim_roll = TRIM_RESET;
	logic [7:0] trim_pitch = TRIM_RESET;
	logic [7:0] center_yaw = CENTER_RESET;
	logic [7:0] center_roll = CENTER_RESET;
	logic [7:0] center_pitch = CENTER_RESET;
	logic [7:0] trim_start [3] = '{TRIM_RESET, TRIM_RESET, TRIM_RESET};

	packet_byte_t expected_bytes [$];
	packet_byte_t popped_byte;
	int           fail_count = 0;
	int           cycle_count = 0;
	bit           push_stalls = 1'b1;
	bit           pop_stalls = 1'b1;

	stick_to_radio_packet_encoder_unit #(
		.PACKET_BYTES(PACKET_BYTES)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.throttle_sample(throttle_sample),
		.yaw_sample     (yaw_sample),
		.roll_sample    (roll_sample),
		.pitch_sample   (pitch_sample),
		.ladder_sample  (ladder_sample),
		.lock_pressed   (lock_pressed),
		.unlock_pressed (unlock_pressed),
		.empty          (empty),
		.pop            (pop),
		.packet_byte    (packet_byte),
		.packet_end     (packet_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("stick_to_radio_packet_encoder_unit regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- model

	function automatic logic [7:0] stick_to_byte(input logic [9:0] raw, input logic [7:0] center);
		int s;
		int c;
		int v;
		s = int'(raw) >> 2;
		c = int'(center);
		if (s > c + 5)
			v = int'(AXIS_MID) + (s - c - 5) / 2;
		else if (s < c - 5)
			v = int'(AXIS_MID) - (c - 5 - s) / 2;
		else
			v = int'(AXIS_MID);
		return 8'(v);
	endfunction

	function automatic logic [2:0] key_from_ladder(input logic [9:0] raw, input logic [2:0] held);
		int a;
		a = int'(raw) >> 2;
		if (a <= 2) return KEY_NONE;
		if (a > 35 && a < 43) return KEY_YAW_UP;
		if (a > 70 && a < 80) return KEY_YAW_DOWN;
		if (a > 108 && a < 117) return KEY_PITCH_UP;
		if (a > 146 && a < 156) return KEY_PITCH_DOWN;
		if (a > 192 && a < 202) return KEY_ROLL_DOWN;
		if (a > 250 && a < 256) return KEY_ROLL_UP;
		// between windows the key keeps its code
		return held;
	endfunction

	task automatic encode_packet(input sample_set_t s);
		int         thr;
		logic [7:0] pkt [PACKET_BYTES];
		logic [7:0] sum;
		logic [2:0] key;
		thr = int'(s.throttle);
		if (thr > int'(THR_MAX)) thr = int'(THR_MAX);

		key = key_from_ladder(s.ladder, held_key);
		if (key != KEY_NONE && key != last_key) begin
			case (key)
				KEY_YAW_UP:     trim_yaw = trim_yaw + 8'd1;
				KEY_YAW_DOWN:   trim_yaw = trim_yaw - 8'd1;
				KEY_PITCH_UP:   trim_pitch = trim_pitch + 8'd1;
				KEY_PITCH_DOWN: trim_pitch = trim_pitch - 8'd1;
				KEY_ROLL_DOWN:  trim_roll = trim_roll - 8'd1;
				KEY_ROLL_UP:    trim_roll = trim_roll + 8'd1;
				default: ;
			endcase
		end
		held_key = key;
		last_key = key;

		// lock first, so unlock wins when both are held at low throttle
		if (s.lock) arm_mode_now = MODE_LOCK;
		if (thr < int'(THR_ARM_MAX) && s.unlock) arm_mode_now = MODE_UNLOCK;

		for (int i = 0; i < PACKET_BYTES; i++) pkt[i] = '0;
		pkt[BYTE_SEQ]        = pkt_seq;
		pkt[BYTE_MODE]       = 8'(arm_mode_now);
		pkt[BYTE_THR_HI]     = 8'(thr / 255);
		pkt[BYTE_THR_LO]     = 8'(thr % 255);
		pkt[BYTE_YAW]        = stick_to_byte(s.yaw, center_yaw);
		pkt[BYTE_ROLL]       = stick_to_byte(s.roll, center_roll);
		pkt[BYTE_PITCH]      = stick_to_byte(s.pitch, center_pitch);
		pkt[BYTE_ROLL_TRIM]  = trim_roll;
		pkt[BYTE_PITCH_TRIM] = trim_pitch;
		pkt[BYTE_YAW_TRIM]   = trim_yaw;
		sum = '0;
		for (int i = 0; i < BYTE_SUM; i++) sum = sum + pkt[i];
		pkt[BYTE_SUM] = sum;
		pkt_seq = pkt_seq + 8'd1;

		for (int i = 0; i < PACKET_BYTES; i++)
			expected_bytes.push_back('{value: pkt[i], last: (i == PACKET_BYTES - 1)});
	endtask

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_bytes.size() == 0) begin
				$error("packet_byte expected none actual %0d", packet_byte);
				fail_count++;
			end else begin
				popped_byte = expected_bytes.pop_front();
				if (packet_byte !== popped_byte.value) begin
					$error("packet_byte expected %0d actual %0d", popped_byte.value, packet_byte);
					fail_count++;
				end
				if (packet_end !== popped_byte.last) begin
					$error("packet_end expected %0d actual %0d", popped_byte.last, packet_end);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- driving

	// mostly back to back, a few long holes
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		int gap;
		forever begin
			gap = pop_stalls ? random_gap() : 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// push stays high after the item so a back to back item follows with no gap
	task automatic send_samples(input sample_set_t s);
		int gap;
		gap = push_stalls ? random_gap() : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push            <= 1'b1;
		throttle_sample <= s.throttle;
		yaw_sample      <= s.yaw;
		roll_sample     <= s.roll;
		pitch_sample    <= s.pitch;
		ladder_sample   <= s.ladder;
		lock_pressed    <= s.lock;
		unlock_pressed  <= s.unlock;
		do @(posedge clk); while (full);
		encode_packet(s);
	endtask

	task automatic wait_for_packets();
		push <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_config(input logic [2:0] index, input logic [7:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		case (index)
			REG_YAW_CENTER:       center_yaw = value;
			REG_ROLL_CENTER:      center_roll = value;
			REG_PITCH_CENTER:     center_pitch = value;
			// the encoder ignores the trim start indexes, so the live trims stay put
			REG_ROLL_TRIM_START:  trim_start[0] = value;
			REG_PITCH_TRIM_START: trim_start[1] = value;
			REG_YAW_TRIM_START:   trim_start[2] = value;
			default: ;
		endcase
	endtask

	task automatic write_all_config(input logic [7:0] yc, input logic [7:0] rc,
			input logic [7:0] pc, input logic [7:0] trim_value);
		write_config(REG_YAW_CENTER, yc);
		write_config(REG_ROLL_CENTER, rc);
		write_config(REG_PITCH_CENTER, pc);
		write_config(REG_ROLL_TRIM_START, trim_value);
		write_config(REG_PITCH_TRIM_START, ~trim_value);
		write_config(REG_YAW_TRIM_START, trim_value ^ 8'h5a);
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic sample_set_t make_samples(input int thr, input int yaw, input int roll,
			input int pitch, input int ladder, input bit lock, input bit unlock);
		sample_set_t s;
		s.throttle = 10'(thr);
		s.yaw      = 10'(yaw);
		s.roll     = 10'(roll);
		s.pitch    = 10'(pitch);
		s.ladder   = 10'(ladder);
		s.lock     = lock;
		s.unlock   = unlock;
		return s;
	endfunction

	function automatic logic [9:0] ladder_pressing(input logic [2:0] key);
		int a;
		case (key)
			KEY_YAW_UP:     a = $urandom_range(36, 42);
			KEY_YAW_DOWN:   a = $urandom_range(71, 79);
			KEY_PITCH_UP:   a = $urandom_range(109, 116);
			KEY_PITCH_DOWN: a = $urandom_range(147, 155);
			KEY_ROLL_DOWN:  a = $urandom_range(193, 201);
			default:        a = $urandom_range(251, 255);
		endcase
		return 10'(a * 4 + int'($urandom_range(0, 3)));
	endfunction

	function automatic logic [9:0] ladder_between();
		int a;
		case ($urandom_range(0, 5))
			0:       a = $urandom_range(3, 35);
			1:       a = $urandom_range(43, 70);
			2:       a = $urandom_range(80, 108);
			3:       a = $urandom_range(117, 146);
			4:       a = $urandom_range(156, 192);
			default: a = $urandom_range(202, 250);
		endcase
		return 10'(a * 4 + int'($urandom_range(0, 3)));
	endfunction

	// a key other than the yaw keys, or a release
	function automatic logic [9:0] ladder_not_yaw();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return ladder_pressing(KEY_ROLL_DOWN);
		if (r < 7) return ladder_pressing(3'($urandom_range(3, 6)));
		return 10'($urandom_range(0, 11));
	endfunction

	// three times in ten near the deadband of the current center
	function automatic logic [9:0] random_axis(input logic [7:0] center);
		int v;
		if ($urandom_range(0, 9) < 3) begin
			v = int'(center) * 4 + int'($urandom_range(0, 63)) - 32;
			if (v < 0) v = 0;
			if (v > 1023) v = 1023;
		end else begin
			v = $urandom_range(0, 1023);
		end
		return 10'(v);
	endfunction

	function automatic sample_set_t random_samples();
		sample_set_t s;
		int          r;
		r = $urandom_range(0, 19);
		if (r < 5)
			s.throttle = 10'($urandom_range(0, 6));
		else if (r < 8)
			s.throttle = 10'($urandom_range(990, 1023));
		else
			s.throttle = 10'($urandom_range(0, 1023));
		s.yaw   = random_axis(center_yaw);
		s.roll  = random_axis(center_roll);
		s.pitch = random_axis(center_pitch);
		r = $urandom_range(0, 9);
		if (r < 4)
			s.ladder = ladder_pressing(3'($urandom_range(1, 6)));
		else if (r < 6)
			s.ladder = 10'($urandom_range(0, 11));
		else if (r < 8)
			s.ladder = ladder_between();
		else
			s.ladder = 10'($urandom_range(0, 1023));
		s.lock   = ($urandom_range(0, 4) == 0);
		s.unlock = ($urandom_range(0, 2) == 0);
		return s;
	endfunction

	task automatic test_power_on_packet();
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b0, 1'b0));
	endtask

	task automatic test_arm_buttons();
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b1, 1'b0));
		// unlock refused at throttle 5, taken at 4
		send_samples(make_samples(5, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b0, 1'b1));
		send_samples(make_samples(4, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b0, 1'b1));
		send_samples(make_samples(1023, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b1, 1'b0));
		send_samples(make_samples(1023, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b1, 1'b1));
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b1, 1'b1));
	endtask

	task automatic test_throttle_clamp();
		send_samples(make_samples(254, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b0, 1'b0));
		send_samples(make_samples(255, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b0, 1'b0));
		send_samples(make_samples(510, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b0, 1'b0));
		send_samples(make_samples(1000, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b0, 1'b0));
		send_samples(make_samples(1001, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b0, 1'b0));
	endtask

	// center 128: edges of the deadband at 123 and 133, half slope beyond
	task automatic test_axis_deadband();
		send_samples(make_samples(0, 0, 1023, 532, 0, 1'b0, 1'b0));
		send_samples(make_samples(0, 543, 492, 485, 0, 1'b0, 1'b0));
		send_samples(make_samples(0, 1023, 0, 536, 0, 1'b0, 1'b0));
	endtask

	task automatic test_trim_keys();
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 156, 1'b0, 1'b0));
		// same key held: no further step
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 144, 1'b0, 1'b0));
		// between windows keeps the held code
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 143, 1'b0, 1'b0));
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 11, 1'b0, 1'b0));
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 300, 1'b0, 1'b0));
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 450, 1'b0, 1'b0));
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 604, 1'b0, 1'b0));
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 789, 1'b0, 1'b0));
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 1015, 1'b0, 1'b0));
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 12, 1'b0, 1'b0));
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 1023, 1'b0, 1'b0));
		send_samples(make_samples(0, CENTER_RAW, CENTER_RAW, CENTER_RAW, 0, 1'b0, 1'b0));
	endtask

	// every other item presses yaw up after another key or a release, so the yaw
	// trim steps on each of those items and wraps past 255 over the run
	task automatic test_random_traffic();
		sample_set_t s;
		int          n;
		n = 0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_for_packets();
			case (phase)
				0: write_all_config(8'd0, 8'd255, 8'd0, 8'd0);
				1: write_all_config(8'd255, 8'd0, 8'd255, 8'd255);
				4: write_all_config(CENTER_RESET, CENTER_RESET, CENTER_RESET, TRIM_RESET);
				default: write_all_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			push_stalls = (phase == 0 || phase == 2 || phase == 4);
			pop_stalls  = (phase == 0 || phase == 3 || phase == 4);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				s = random_samples();
				s.ladder = (n % 2 == 0) ? ladder_pressing(KEY_YAW_UP) : ladder_not_yaw();
				n++;
				send_samples(s);
			end
		end
		push_stalls = 1'b1;
		pop_stalls  = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_power_on_packet();
		test_arm_buttons();
		test_throttle_clamp();
		test_axis_deadband();
		test_trim_keys();
		test_random_traffic();

		wait_for_packets();
		repeat (4 * PACKET_BYTES) @(posedge clk);
		if (fail_count == 0)
			$display("stick_to_radio_packet_encoder_unit regression: pass");
		else
			$display("stick_to_radio_packet_encoder_unit regression: fail");
		$finish;
	end

endmodule
